FILE: rtl/orsat_pkg.sv
package orsat_pkg;

  localparam int NUM_AXES    = 4;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_RECTS   = 2;

  // axis code reported when no axis separates the pair
  localparam logic [2:0] AXIS_NONE = 3'd4;

endpackage

FILE: rtl/orsat_in_if.sv
interface orsat_in_if #(
  parameter int COORD_BITS     = 24,
  parameter int UNIT_FRAC_BITS = 14
) ();
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic signed [UNIT_FRAC_BITS+1:0]  dir_cos;
  logic signed [UNIT_FRAC_BITS+1:0]  dir_sin;
  logic signed [COORD_BITS-1:0]      corner0_x;
  logic signed [COORD_BITS-1:0]      corner0_y;
  logic signed [COORD_BITS-1:0]      corner1_x;
  logic signed [COORD_BITS-1:0]      corner1_y;
  logic signed [COORD_BITS-1:0]      corner2_x;
  logic signed [COORD_BITS-1:0]      corner2_y;
  logic signed [COORD_BITS-1:0]      corner3_x;
  logic signed [COORD_BITS-1:0]      corner3_y;

  modport source (
    output valid, action, dir_cos, dir_sin,
           corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );

  modport sink (
    input  valid, action, dir_cos, dir_sin,
           corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

FILE: rtl/orsat_out_if.sv
interface orsat_out_if ();
  logic       valid;
  logic       ready;
  logic       collide;
  logic [2:0] separating_axis;

  modport source (output valid, collide, separating_axis, input ready);
  modport sink   (input valid, collide, separating_axis, output ready);
endinterface

FILE: rtl/oriented_rect_sat_overlap.sv
// Separating axis test between two oriented rectangles in exact fixed point.
// A request with action 0 stores its rectangle as the first one and yields no
// result; a request with action 1 tests its rectangle against the stored one
// and yields one result: collide, and the first separating axis in the order
// first direction, first normal, second direction, second normal (4 = none).
// Touching counts as overlap. A load takes effect for every later request.
// One request is accepted per clock while the output is not stalled; a test
// result passes through five register stages, which are:
// axis setup, the 64 coordinate products, the 32 dot-product sums, the
// per-axis min/max trees, and the interval compare with the output register.
// The whole pipeline advances together, so ready drops only while a result
// waits at the output and the sink is not ready.
module oriented_rect_sat_overlap #(
  parameter int COORD_BITS     = 24,
  parameter int UNIT_FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  orsat_in_if.sink    items,
  orsat_out_if.source results
);
  import orsat_pkg::*;

  localparam int UB = UNIT_FRAC_BITS + 2;
  localparam int AW = UB + 1;
  localparam int CW = COORD_BITS;
  localparam int SW = AW + CW + 1;

  logic en;
  logic acc;
  logic v_a, v_b, v_c, v_d, v_e;

  logic signed [CW-1:0] cx_in [NUM_CORNERS];
  logic signed [CW-1:0] cy_in [NUM_CORNERS];
  logic signed [AW-1:0] ax [NUM_AXES];
  logic signed [AW-1:0] ay [NUM_AXES];
  logic signed [CW-1:0] cx [NUM_RECTS][NUM_CORNERS];
  logic signed [CW-1:0] cy [NUM_RECTS][NUM_CORNERS];
  logic signed [SW-1:0] dot [NUM_AXES][NUM_RECTS][NUM_CORNERS];

  assign en  = !v_e || results.ready;
  assign acc = items.valid && en;

  assign items.ready   = en;
  assign results.valid = v_e;

  assign cx_in[0] = items.corner0_x;
  assign cy_in[0] = items.corner0_y;
  assign cx_in[1] = items.corner1_x;
  assign cy_in[1] = items.corner1_y;
  assign cx_in[2] = items.corner2_x;
  assign cy_in[2] = items.corner2_y;
  assign cx_in[3] = items.corner3_x;
  assign cy_in[3] = items.corner3_y;

  // only test requests travel down the pipe as valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
    end else if (en) begin
      v_a <= acc && items.action;
      v_b <= v_a;
      v_c <= v_b;
      v_d <= v_c;
      v_e <= v_d;
    end
  end

  orsat_front #(.CW(CW), .UB(UB), .AW(AW)) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .load    (acc && !items.action),
    .dir_cos (items.dir_cos),
    .dir_sin (items.dir_sin),
    .cx_in   (cx_in),
    .cy_in   (cy_in),
    .ax      (ax),
    .ay      (ay),
    .cx      (cx),
    .cy      (cy)
  );

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    for (genvar r = 0; r < NUM_RECTS; r++) begin : g_rect
      for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
        orsat_dot #(.CW(CW), .AW(AW)) u_dot (
          .clk (clk),
          .en  (en),
          .ax  (ax[a]),
          .ay  (ay[a]),
          .x   (cx[r][k]),
          .y   (cy[r][k]),
          .dot (dot[a][r][k])
        );
      end
    end
  end

  orsat_sep #(.SW(SW)) u_sep (
    .clk             (clk),
    .en              (en),
    .dot             (dot),
    .collide         (results.collide),
    .separating_axis (results.separating_axis)
  );

endmodule

FILE: rtl/orsat_front.sv
module orsat_front #(
  parameter int CW = 24,
  parameter int UB = 16,
  parameter int AW = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  load,
  input  logic signed [UB-1:0]  dir_cos,
  input  logic signed [UB-1:0]  dir_sin,
  input  logic signed [CW-1:0]  cx_in [orsat_pkg::NUM_CORNERS],
  input  logic signed [CW-1:0]  cy_in [orsat_pkg::NUM_CORNERS],
  output logic signed [AW-1:0]  ax [orsat_pkg::NUM_AXES],
  output logic signed [AW-1:0]  ay [orsat_pkg::NUM_AXES],
  output logic signed [CW-1:0]  cx [orsat_pkg::NUM_RECTS][orsat_pkg::NUM_CORNERS],
  output logic signed [CW-1:0]  cy [orsat_pkg::NUM_RECTS][orsat_pkg::NUM_CORNERS]
);
  import orsat_pkg::*;

  // stored first rectangle
  logic signed [UB-1:0] first_cos;
  logic signed [UB-1:0] first_sin;
  logic signed [CW-1:0] first_x [NUM_CORNERS];
  logic signed [CW-1:0] first_y [NUM_CORNERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_cos <= '0;
      first_sin <= '0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        first_x[k] <= '0;
        first_y[k] <= '0;
      end
    end else if (load) begin
      first_cos <= dir_cos;
      first_sin <= dir_sin;
      for (int k = 0; k < NUM_CORNERS; k++) begin
        first_x[k] <= cx_in[k];
        first_y[k] <= cy_in[k];
      end
    end
  end

  // stage A: axes and both corner sets; the sine is widened by one bit
  // so that negating the most negative code stays exact
  always_ff @(posedge clk) begin
    if (en) begin
      ax[0] <= AW'(first_cos);
      ay[0] <= AW'(first_sin);
      ax[1] <= -AW'(first_sin);
      ay[1] <= AW'(first_cos);
      ax[2] <= AW'(dir_cos);
      ay[2] <= AW'(dir_sin);
      ax[3] <= -AW'(dir_sin);
      ay[3] <= AW'(dir_cos);
      for (int k = 0; k < NUM_CORNERS; k++) begin
        cx[0][k] <= first_x[k];
        cy[0][k] <= first_y[k];
        cx[1][k] <= cx_in[k];
        cy[1][k] <= cy_in[k];
      end
    end
  end

endmodule

FILE: rtl/orsat_dot.sv
module orsat_dot #(
  parameter int CW = 24,
  parameter int AW = 17
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    ax,
  input  logic signed [AW-1:0]    ay,
  input  logic signed [CW-1:0]    x,
  input  logic signed [CW-1:0]    y,
  output logic signed [AW+CW:0]   dot
);
  localparam int PW = AW + CW;

  logic signed [PW-1:0] px;
  logic signed [PW-1:0] py;

  // stage B: products, stage C: sum
  always_ff @(posedge clk) begin
    if (en) begin
      px  <= PW'(ax) * PW'(x);
      py  <= PW'(ay) * PW'(y);
      dot <= (PW + 1)'(px) + (PW + 1)'(py);
    end
  end

endmodule

FILE: rtl/orsat_sep.sv
module orsat_sep #(
  parameter int SW = 41
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [SW-1:0]  dot [orsat_pkg::NUM_AXES][orsat_pkg::NUM_RECTS]
                                    [orsat_pkg::NUM_CORNERS],
  output logic                  collide,
  output logic [2:0]            separating_axis
);
  import orsat_pkg::*;

  logic signed [SW-1:0] lo [NUM_AXES][NUM_RECTS];
  logic signed [SW-1:0] hi [NUM_AXES][NUM_RECTS];
  logic signed [SW-1:0] lo_next [NUM_AXES][NUM_RECTS];
  logic signed [SW-1:0] hi_next [NUM_AXES][NUM_RECTS];
  logic [NUM_AXES-1:0]  sep;
  logic [2:0]           axis_next;

  // two-level min/max tree over the four corners
  always_comb begin
    logic signed [SW-1:0] l01, l23, h01, h23;
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int r = 0; r < NUM_RECTS; r++) begin
        l01 = (dot[a][r][1] < dot[a][r][0]) ? dot[a][r][1] : dot[a][r][0];
        l23 = (dot[a][r][3] < dot[a][r][2]) ? dot[a][r][3] : dot[a][r][2];
        h01 = (dot[a][r][1] > dot[a][r][0]) ? dot[a][r][1] : dot[a][r][0];
        h23 = (dot[a][r][3] > dot[a][r][2]) ? dot[a][r][3] : dot[a][r][2];
        lo_next[a][r] = (l23 < l01) ? l23 : l01;
        hi_next[a][r] = (h23 > h01) ? h23 : h01;
      end
    end
  end

  // touching intervals are not separated
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sep[a] = (lo[a][1] > hi[a][0]) || (lo[a][0] > hi[a][1]);
    end
    axis_next = AXIS_NONE;
    for (int a = NUM_AXES - 1; a >= 0; a--) begin
      if (sep[a]) axis_next = 3'(a);
    end
  end

  // stage D: intervals, stage E: result register
  always_ff @(posedge clk) begin
    if (en) begin
      lo              <= lo_next;
      hi              <= hi_next;
      separating_axis <= axis_next;
      collide         <= (axis_next == AXIS_NONE);
    end
  end

endmodule

FILE: rtl/orsat_check.sv
module orsat_check (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       collide,
  input logic [2:0] separating_axis
);
  import orsat_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_collide_axis: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (collide == (separating_axis == AXIS_NONE)))
    else $error("collide flag disagrees with separating axis");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(collide)
                                && $stable(separating_axis))
    else $error("stalled result changed");

endmodule

bind oriented_rect_sat_overlap orsat_check u_orsat_check (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (items.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .collide         (results.collide),
  .separating_axis (results.separating_axis)
);

FILE: tb/oriented_rect_sat_overlap_test.sv
module oriented_rect_sat_overlap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import orsat_pkg::*;

  localparam int COORD_BITS     = 24;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int UNIT_BITS      = UNIT_FRAC_BITS + 2;
  localparam int UNIT_ONE       = 1 << UNIT_FRAC_BITS;
  localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
  localparam int DIR_MAX        = (1 << (UNIT_BITS - 1)) - 1;
  localparam int DIR_MIN        = -(1 << (UNIT_BITS - 1));

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEST = 1'b1;

  localparam int N_ITEMS      = 700;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 4000;
  localparam real PI          = 3.14159265358979;

  typedef struct packed {
    logic                                  action;
    logic [UNIT_BITS-1:0]                  c;
    logic [UNIT_BITS-1:0]                  s;
    logic [NUM_CORNERS-1:0][COORD_BITS-1:0] x;
    logic [NUM_CORNERS-1:0][COORD_BITS-1:0] y;
  } rect_req_t;

  typedef struct packed {
    logic       collide;
    logic [2:0] separating_axis;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rect_req_t in_req    = '0;
  logic      in_valid  = 1'b0;
  logic      out_ready = 1'b0;

  orsat_in_if #(.COORD_BITS(COORD_BITS), .UNIT_FRAC_BITS(UNIT_FRAC_BITS)) rect_in ();
  orsat_out_if verdict_out ();

  assign rect_in.valid     = in_valid;
  assign rect_in.action    = in_req.action;
  assign rect_in.dir_cos   = in_req.c;
  assign rect_in.dir_sin   = in_req.s;
  assign rect_in.corner0_x = in_req.x[0];
  assign rect_in.corner0_y = in_req.y[0];
  assign rect_in.corner1_x = in_req.x[1];
  assign rect_in.corner1_y = in_req.y[1];
  assign rect_in.corner2_x = in_req.x[2];
  assign rect_in.corner2_y = in_req.y[2];
  assign rect_in.corner3_x = in_req.x[3];
  assign rect_in.corner3_y = in_req.y[3];
  assign verdict_out.ready = out_ready;

  oriented_rect_sat_overlap #(
    .COORD_BITS(COORD_BITS),
    .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(rect_in),
    .results(verdict_out)
  );

  rect_req_t rect_requests[$];
  verdict_t  expected_verdicts[$];
  rect_req_t first_rect = '0;
  rect_req_t cur_req    = '0;
  int        n_planned  = 0;
  int        n_sent     = 0;
  int        n_errors   = 0;
  int        idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  // exact projections of both rectangles on the four axes, first gap wins
  function automatic verdict_t sat_verdict(rect_req_t a, rect_req_t b);
    longint ax[NUM_AXES], ay[NUM_AXES];
    longint px[NUM_RECTS][NUM_CORNERS], py[NUM_RECTS][NUM_CORNERS];
    longint lo[NUM_RECTS], hi[NUM_RECTS];
    longint p;
    verdict_t v;
    ax[0] = longint'($signed(a.c));
    ay[0] = longint'($signed(a.s));
    ax[1] = -ay[0];
    ay[1] = ax[0];
    ax[2] = longint'($signed(b.c));
    ay[2] = longint'($signed(b.s));
    ax[3] = -ay[2];
    ay[3] = ax[2];
    for (int k = 0; k < NUM_CORNERS; k++) begin
      px[0][k] = longint'($signed(a.x[k]));
      py[0][k] = longint'($signed(a.y[k]));
      px[1][k] = longint'($signed(b.x[k]));
      py[1][k] = longint'($signed(b.y[k]));
    end
    v.separating_axis = AXIS_NONE;
    for (int k = 0; k < NUM_AXES; k++) begin
      if (v.separating_axis == AXIS_NONE) begin
        for (int r = 0; r < NUM_RECTS; r++) begin
          for (int j = 0; j < NUM_CORNERS; j++) begin
            p = ax[k] * px[r][j] + ay[k] * py[r][j];
            if (j == 0 || p < lo[r]) lo[r] = p;
            if (j == 0 || p > hi[r]) hi[r] = p;
          end
        end
        if (lo[1] > hi[0] || lo[0] > hi[1]) v.separating_axis = 3'(k);
      end
    end
    v.collide = (v.separating_axis == AXIS_NONE);
    return v;
  endfunction

  function automatic logic [COORD_BITS-1:0] coord(real v);
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
    return COORD_BITS'($rtoi(v));
  endfunction

  function automatic int rnd_span(int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  function automatic rect_req_t aabb(logic action, int x0, int y0, int x1, int y1);
    rect_req_t r;
    r.action = action;
    r.c = UNIT_BITS'(UNIT_ONE);
    r.s = '0;
    r.x[0] = COORD_BITS'(x1); r.y[0] = COORD_BITS'(y1);
    r.x[1] = COORD_BITS'(x0); r.y[1] = COORD_BITS'(y1);
    r.x[2] = COORD_BITS'(x0); r.y[2] = COORD_BITS'(y0);
    r.x[3] = COORD_BITS'(x1); r.y[3] = COORD_BITS'(y0);
    return r;
  endfunction

  function automatic rect_req_t oriented(logic action, real cx, real cy, real hw, real hh,
                                         real theta);
    rect_req_t r;
    real c, s;
    c = $cos(theta);
    s = $sin(theta);
    r.action = action;
    r.c = UNIT_BITS'($rtoi(c * UNIT_ONE));
    r.s = UNIT_BITS'($rtoi(s * UNIT_ONE));
    r.x[0] = coord(cx + hw * c - hh * s); r.y[0] = coord(cy + hw * s + hh * c);
    r.x[1] = coord(cx - hw * c - hh * s); r.y[1] = coord(cy - hw * s + hh * c);
    r.x[2] = coord(cx - hw * c + hh * s); r.y[2] = coord(cy - hw * s - hh * c);
    r.x[3] = coord(cx + hw * c + hh * s); r.y[3] = coord(cy + hw * s - hh * c);
    return r;
  endfunction

  function automatic rect_req_t uniform(logic action, int c, int s, int v);
    rect_req_t r;
    r.action = action;
    r.c = UNIT_BITS'(c);
    r.s = UNIT_BITS'(s);
    for (int k = 0; k < NUM_CORNERS; k++) begin
      r.x[k] = COORD_BITS'(v);
      r.y[k] = COORD_BITS'(v);
    end
    return r;
  endfunction

  function automatic int pick_dir();
    case ($urandom_range(4))
      0: return DIR_MAX;
      1: return DIR_MIN;
      2: return UNIT_ONE;
      3: return -UNIT_ONE;
      default: return 0;
    endcase
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(4))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic rect_req_t extreme_rect(logic action);
    rect_req_t r;
    r.action = action;
    r.c = UNIT_BITS'(pick_dir());
    r.s = UNIT_BITS'(pick_dir());
    for (int k = 0; k < NUM_CORNERS; k++) begin
      r.x[k] = COORD_BITS'(pick_coord());
      r.y[k] = COORD_BITS'(pick_coord());
    end
    return r;
  endfunction

  function automatic rect_req_t noise_rect();
    rect_req_t r;
    r.action = 1'($urandom);
    r.c = UNIT_BITS'($urandom);
    r.s = UNIT_BITS'($urandom);
    for (int k = 0; k < NUM_CORNERS; k++) begin
      r.x[k] = COORD_BITS'($urandom);
      r.y[k] = COORD_BITS'($urandom);
    end
    return r;
  endfunction

  // small grid rectangles so shared edges come up often
  function automatic rect_req_t grid_rect(logic action);
    int x0, y0;
    rect_req_t r;
    x0 = 64 * int'($urandom_range(8));
    y0 = 64 * int'($urandom_range(8));
    r = aabb(action, x0, y0, x0 + 64 * int'($urandom_range(4)),
             y0 + 64 * int'($urandom_range(4)));
    if ($urandom_range(1)) begin
      r.c = '0;
      r.s = UNIT_BITS'($urandom_range(1) ? UNIT_ONE : -UNIT_ONE);
    end
    return r;
  endfunction

  function automatic int idle_pct(bit sender);
    if (n_sent * 3 < n_planned) return sender ? 20 : 88;
    if (n_sent * 3 < 2 * n_planned) return sender ? 88 : 20;
    return 0;
  endfunction

  initial begin : stimulus
    rect_req_t r;
    int scale, cx, cy, n_tests;
    // no load yet: first rectangle is all zero
    rect_requests.push_back(aabb(ACT_TEST, 0, 0, 256, 256));
    rect_requests.push_back(aabb(ACT_TEST, 512, 512, 768, 768));
    rect_requests.push_back(aabb(ACT_LOAD, 0, 0, 1024, 1024));
    rect_requests.push_back(aabb(ACT_TEST, 1024, 0, 2048, 1024));
    rect_requests.push_back(aabb(ACT_TEST, 1025, 0, 2048, 1024));
    rect_requests.push_back(aabb(ACT_TEST, -1000, -2000, 1024, -1));
    rect_requests.push_back(aabb(ACT_TEST, 0, 1024, 1024, 2000));
    rect_requests.push_back(oriented(ACT_TEST, 1624.0, 1624.0, 600.0, 600.0, PI / 4.0));
    rect_requests.push_back(oriented(ACT_TEST, 1624.0, 1624.0, 600.0, 600.0, -PI / 4.0));
    rect_requests.push_back(aabb(ACT_TEST, 0, 0, 1024, 1024));
    rect_requests.push_back(oriented(ACT_TEST, 512.0, 512.0, 300.0, 100.0, 0.5));
    // zero-length direction on the stored rectangle
    r = aabb(ACT_LOAD, 0, 0, 1024, 1024);
    r.c = '0;
    r.s = '0;
    rect_requests.push_back(r);
    rect_requests.push_back(aabb(ACT_TEST, 2000, 0, 3000, 1024));
    rect_requests.push_back(uniform(ACT_LOAD, DIR_MAX, DIR_MAX, COORD_MAX));
    rect_requests.push_back(uniform(ACT_TEST, DIR_MIN, DIR_MIN, COORD_MIN));
    rect_requests.push_back(uniform(ACT_LOAD, DIR_MIN, UNIT_ONE, COORD_MIN));
    rect_requests.push_back(uniform(ACT_TEST, UNIT_ONE, DIR_MIN, COORD_MAX));
    for (int i = 0; i < 6; i++)
      rect_requests.push_back(extreme_rect(i % 2 ? ACT_TEST : ACT_LOAD));

    while (rect_requests.size() < N_ITEMS) begin
      if ($urandom_range(99) < 15) begin
        rect_requests.push_back(noise_rect());
      end else if ($urandom_range(99) < 30) begin
        rect_requests.push_back(grid_rect(ACT_LOAD));
        n_tests = 1 + $urandom_range(3);
        repeat (n_tests) rect_requests.push_back(grid_rect(ACT_TEST));
      end else begin
        case ($urandom_range(3))
          0: scale = 256;
          1: scale = 4096;
          2: scale = 65536;
          default: scale = 2000000;
        endcase
        cx = rnd_span(scale);
        cy = rnd_span(scale);
        rect_requests.push_back(oriented(ACT_LOAD, cx, cy, $urandom_range(scale),
                                         $urandom_range(scale),
                                         $urandom_range(3599) * PI / 1800.0));
        n_tests = 1 + $urandom_range(3);
        repeat (n_tests)
          rect_requests.push_back(oriented(ACT_TEST, cx + rnd_span(3 * scale),
                                           cy + rnd_span(3 * scale),
                                           $urandom_range(scale), $urandom_range(scale),
                                           $urandom_range(3599) * PI / 1800.0));
      end
    end
    n_planned = rect_requests.size();

    while (n_sent < n_planned || expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("** oriented_rect_sat_overlap: PASSED **");
    end else begin
      $display("** oriented_rect_sat_overlap: FAILED **");
    end
    $finish;
  end

  always @(posedge clk) begin : driver
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (rect_in.valid && rect_in.ready) begin
        if (cur_req.action == ACT_LOAD) first_rect = cur_req;
        else expected_verdicts.push_back(sat_verdict(first_rect, cur_req));
        n_sent++;
      end
      if (!rect_in.valid || rect_in.ready) begin
        if (rect_requests.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          cur_req = rect_requests.pop_front();
          in_req <= cur_req;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    verdict_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (verdict_out.valid && verdict_out.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result: collide %0d, separating_axis %0d",
                 verdict_out.collide, verdict_out.separating_axis);
          n_errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_out.collide !== want.collide) begin
            $error("collide: expected %0d, got %0d", want.collide, verdict_out.collide);
            n_errors++;
          end
          if (verdict_out.separating_axis !== want.separating_axis) begin
            $error("separating_axis: expected %0d, got %0d",
                   want.separating_axis, verdict_out.separating_axis);
            n_errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((rect_in.valid && rect_in.ready) || (verdict_out.valid && verdict_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** oriented_rect_sat_overlap: FAILED **");
        $finish;
      end
    end
  end

endmodule
